FILE: rtl/scfla_pkg.sv
package scfla_pkg;

	// fixed field widths of the request and response words
	localparam int CMD_W    = 1;
	localparam int REQ_W    = 17;
	localparam int ADDR_W   = 20;
	localparam int STATUS_W = 2;
	localparam int CHUNK_W  = 17;

	// request plus header, and chunk sizes up to one past the largest page
	localparam int SIZE_W    = 18;
	localparam int TAG_W     = 4;
	localparam int LINK_W    = ADDR_W + 1;
	localparam int HDR_BYTES = 8;

	localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK        = 2'd0,
		STATUS_TOO_LARGE = 2'd1,
		STATUS_NO_MEMORY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_REFILL,
		ST_POP_RD
	} state_t;

endpackage

FILE: rtl/size_class_free_list_allocator_top.sv
// Segregated free-list allocator over a heap of HEAP_PAGES pages of PAGE_BYTES bytes in a 20-bit
// byte space. An allocate word adds an 8-byte header, rounds up to a power of two of at least
// 2**MIN_CHUNK_LOG2 bytes and pops a chunk of that class, answering base plus 8 and the chunk
// size; a request beyond a page or beyond the last class answers too_large, and an empty class
// with no unused page left answers out_of_memory. A free word looks up the chunk's class tag and
// pushes it back; it always answers ok with zero fields. Each request word yields exactly one
// response word. After reset the block sweeps every entry of the class tag memory with
// req_stall high. After that a word is handled in two steps: ST_IDLE accepts it and issues the
// synchronous tag or link memory read, and ST_EXEC updates the list head and loads the response
// register, waiting there while the response register holds a stalled response. A new word is
// taken only in ST_IDLE, so the block does not take the next word before it is through with the
// last. An allocate that finds its class empty threads a fresh page first in ST_REFILL, writing
// one chunk per cycle to the tag and link memories, then reads the new head in ST_POP_RD. The
// response register lets the next word be accepted while an earlier response is still stalled.
module size_class_free_list_allocator_top #(
	parameter int PAGE_BYTES     = 65536,
	parameter int HEAP_PAGES     = 16,
	parameter int NUM_CLASSES    = 11,
	parameter int MIN_CHUNK_LOG2 = 6
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// request channel
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [scfla_pkg::CMD_W-1:0]       command,
	input  logic [scfla_pkg::REQ_W-1:0]       request_bytes,
	input  logic [scfla_pkg::ADDR_W-1:0]      user_address,
	// response channel
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic [scfla_pkg::STATUS_W-1:0]    status,
	output logic [scfla_pkg::ADDR_W-1:0]      granted_address,
	output logic [scfla_pkg::CHUNK_W-1:0]     chunk_bytes
);
	import scfla_pkg::*;

	// one tag and one link entry per minimum-size chunk of the address space
	localparam int IDX_W      = ADDR_W - MIN_CHUNK_LOG2;
	localparam int DEPTH      = 1 << IDX_W;
	// pages that fit in the 20-bit space bound the heap
	localparam int PAGE_FIT   = (1 << ADDR_W) / PAGE_BYTES;
	localparam int PAGE_LIMIT = (HEAP_PAGES < PAGE_FIT) ? HEAP_PAGES : PAGE_FIT;
	localparam int PG_W       = $clog2(PAGE_LIMIT + 1);
	localparam int CIDX_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	// size thresholds 2**MIN .. 2**16 against the request plus header
	localparam int NCMP       = SIZE_W - 1 - MIN_CHUNK_LOG2;
	localparam int OFF_W      = $clog2(PAGE_BYTES + 1);
	localparam int SUM_W      = OFF_W + 2;

	function automatic logic [IDX_W-1:0] store_idx(input logic [ADDR_W-1:0] a);
		return a[ADDR_W-1 -: IDX_W];
	endfunction

	// class tags past the last class map to class 0 and never index past the head registers
	function automatic logic [CIDX_W-1:0] class_idx(input logic [TAG_W-1:0] c);
		return (c < TAG_W'(NUM_CLASSES)) ? CIDX_W'(c) : '0;
	endfunction

	state_t state_q, state_nx;

	// memories and their registered read data
	logic [TAG_W-1:0]  tag_ram [DEPTH];
	logic [LINK_W-1:0] link_ram [DEPTH];
	logic [TAG_W-1:0]  tag_rd_q;
	logic [LINK_W-1:0] link_rd_q;

	logic              tag_we, tag_re, link_we, link_re;
	logic [IDX_W-1:0]  tag_waddr, tag_raddr, link_waddr, link_raddr;
	logic [TAG_W-1:0]  tag_wdata;
	logic [LINK_W-1:0] link_wdata;

	// list heads, one per class
	logic [ADDR_W-1:0] head_q [NUM_CLASSES];
	logic [NUM_CLASSES-1:0] head_vld_q;
	logic [CIDX_W-1:0] head_ridx, head_widx;
	logic [ADDR_W-1:0] head_rd, head_wdata;
	logic              head_rd_vld, head_we, head_wvld;

	// heap growth
	logic [PG_W-1:0]   next_page_q;
	logic [ADDR_W-1:0] page_base_q;
	logic [OFF_W-1:0]  off_q;
	logic [IDX_W-1:0]  clr_q;

	// word being worked on
	logic [CMD_W-1:0]   cmd_s1;
	logic [TAG_W-1:0]   cls_s1;
	logic [CHUNK_W-1:0] size_s1;
	logic               too_large_s1;
	logic [ADDR_W-1:0]  base_s1;

	// response register
	logic               rsp_valid_q;
	status_t            status_q;
	logic [ADDR_W-1:0]  granted_q;
	logic [CHUNK_W-1:0] chunk_q;

	// request decode
	logic [SIZE_W-1:0] padded_bytes, dec_size;
	logic [NCMP-1:0]   below;
	logic [TAG_W-1:0]  dec_cls;
	logic              dec_too_large;
	logic [ADDR_W-1:0] free_base;

	// control strobes
	logic               accept, load_s1, pop_load, done, start_refill, refill_done;
	logic               out_free, clr_last, refill_last;
	logic [ADDR_W-1:0]  here;
	status_t            rsp_status;
	logic [ADDR_W-1:0]  rsp_addr;
	logic [CHUNK_W-1:0] rsp_chunk;

	// size class: count the powers of two that are still too small
	always_comb begin
		padded_bytes = SIZE_W'(request_bytes) + SIZE_W'(HDR_BYTES);
		for (int c = 0; c < NCMP; c++) begin
			below[c] = (SIZE_W'(1) << (MIN_CHUNK_LOG2 + c)) < padded_bytes;
		end
		dec_cls       = TAG_W'($countones(below));
		dec_size      = SIZE_W'(1) << (SIZE_W'(MIN_CHUNK_LOG2) + SIZE_W'(dec_cls));
		dec_too_large = (request_bytes > REQ_W'(PAGE_BYTES))
			|| (dec_cls >= TAG_W'(NUM_CLASSES))
			|| (dec_size > SIZE_W'(PAGE_BYTES));
	end

	assign free_base = user_address - ADDR_W'(HDR_BYTES);

	// single read port on the head registers, address picked by state
	always_comb begin
		unique case (state_q)
			ST_IDLE:   head_ridx = class_idx(dec_cls);
			ST_POP_RD: head_ridx = class_idx(cls_s1);
			default:   head_ridx = (cmd_s1 == CMD_FREE) ? class_idx(tag_rd_q) : class_idx(cls_s1);
		endcase
	end
	assign head_rd     = head_q[head_ridx];
	assign head_rd_vld = head_vld_q[head_ridx];

	assign out_free    = !rsp_valid_q || !rsp_stall;
	assign clr_last    = &clr_q;
	assign here        = page_base_q + ADDR_W'(off_q);
	// last chunk of the page when a further chunk would run past its end
	assign refill_last = (SUM_W'(off_q) + SUM_W'(size_s1) + SUM_W'(size_s1))
		> SUM_W'(PAGE_BYTES);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR:  if (clr_last) state_nx = ST_IDLE;
			ST_IDLE:   if (accept) state_nx = ST_EXEC;
			ST_EXEC: begin
				if (done) state_nx = ST_IDLE;
				else if (start_refill) state_nx = ST_REFILL;
			end
			ST_REFILL: if (refill_done) state_nx = ST_POP_RD;
			ST_POP_RD: state_nx = ST_EXEC;
			default:   state_nx = ST_IDLE;
		endcase
	end

	// per-state strobes and memory accesses
	always_comb begin
		req_stall    = (state_q != ST_IDLE);
		accept       = 1'b0;
		load_s1      = 1'b0;
		pop_load     = 1'b0;
		done         = 1'b0;
		start_refill = 1'b0;
		refill_done  = 1'b0;
		tag_we       = 1'b0;
		tag_re       = 1'b0;
		link_we      = 1'b0;
		link_re      = 1'b0;
		tag_waddr    = store_idx(base_s1);
		tag_raddr    = store_idx(free_base);
		tag_wdata    = cls_s1;
		link_waddr   = store_idx(base_s1);
		link_raddr   = store_idx(head_rd);
		link_wdata   = '0;
		head_we      = 1'b0;
		head_widx    = class_idx(cls_s1);
		head_wdata   = base_s1;
		head_wvld    = 1'b1;
		rsp_status   = STATUS_OK;
		rsp_addr     = '0;
		rsp_chunk    = '0;
		unique case (state_q)
			ST_CLEAR: begin
				tag_we    = 1'b1;
				tag_waddr = clr_q;
				tag_wdata = '0;
			end
			ST_IDLE: begin
				accept  = req_valid;
				load_s1 = req_valid;
				if (req_valid) begin
					if (command == CMD_FREE) tag_re = 1'b1;
					else link_re = 1'b1;
				end
			end
			ST_POP_RD: begin
				link_re  = 1'b1;
				pop_load = 1'b1;
			end
			ST_EXEC: begin
				if (out_free) begin
					if (cmd_s1 == CMD_FREE) begin
						// push onto the list named by the stored tag
						done = 1'b1;
						if (tag_rd_q < TAG_W'(NUM_CLASSES)) begin
							link_we    = 1'b1;
							link_wdata = head_rd_vld ? {1'b1, head_rd} : '0;
							head_we    = 1'b1;
							head_widx  = class_idx(tag_rd_q);
						end
					end else if (too_large_s1) begin
						done       = 1'b1;
						rsp_status = STATUS_TOO_LARGE;
					end else if (head_rd_vld) begin
						// pop: next link becomes the head, chunk gets retagged
						done       = 1'b1;
						head_we    = 1'b1;
						head_wdata = link_rd_q[ADDR_W-1:0];
						head_wvld  = link_rd_q[ADDR_W];
						tag_we     = 1'b1;
						rsp_addr   = base_s1 + ADDR_W'(HDR_BYTES);
						rsp_chunk  = size_s1;
					end else if (next_page_q < PG_W'(PAGE_LIMIT)) begin
						start_refill = 1'b1;
					end else begin
						done       = 1'b1;
						rsp_status = STATUS_NO_MEMORY;
					end
				end
			end
			ST_REFILL: begin
				tag_we     = 1'b1;
				tag_waddr  = store_idx(here);
				link_we    = 1'b1;
				link_waddr = store_idx(here);
				link_wdata = refill_last ? '0 : {1'b1, here + ADDR_W'(size_s1)};
				if (refill_last) begin
					refill_done = 1'b1;
					head_we     = 1'b1;
					head_wdata  = page_base_q;
				end
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	// tag clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// page allocation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_page_q <= '0;
			page_base_q <= '0;
		end else if (refill_done) begin
			next_page_q <= next_page_q + 1'b1;
			page_base_q <= page_base_q + ADDR_W'(PAGE_BYTES);
		end
	end

	always_ff @(posedge clk) begin
		if (start_refill) begin
			off_q <= '0;
		end else if (state_q == ST_REFILL) begin
			off_q <= off_q + OFF_W'(size_s1);
		end
	end

	// head registers; only the valid bits need a reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= '0;
		end else if (head_we) begin
			head_vld_q[head_widx] <= head_wvld;
		end
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_q[head_widx] <= head_wdata;
		end
	end

	// tag and link memories with registered synchronous reads
	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_ram[tag_waddr] <= tag_wdata;
		end
		if (tag_re) begin
			tag_rd_q <= tag_ram[tag_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_ram[link_waddr] <= link_wdata;
		end
		if (link_re) begin
			link_rd_q <= link_ram[link_raddr];
		end
	end

	// word under work
	always_ff @(posedge clk) begin
		if (load_s1) begin
			cmd_s1       <= command;
			cls_s1       <= dec_cls;
			size_s1      <= CHUNK_W'(dec_size);
			too_large_s1 <= dec_too_large;
			base_s1      <= (command == CMD_FREE) ? free_base : head_rd;
		end else if (pop_load) begin
			base_s1 <= head_rd;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			status_q  <= rsp_status;
			granted_q <= rsp_addr;
			chunk_q   <= rsp_chunk;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign status          = status_q;
	assign granted_address = granted_q;
	assign chunk_bytes     = chunk_q;

endmodule
